FILE: hdl/u2u_pkg.sv
// ----------------------------------------------------------------------------
// u2u_pkg
// Types and constants shared by the UTF-8 to UTF-16 transcoder modules.
// ----------------------------------------------------------------------------
package u2u_pkg;

    // Input transaction: one UTF-8 byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    // Output transaction: one UTF-16 code unit
    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } t_out_item;

    localparam int unsigned MaxUnits = 4;

    // All code units caused by one input byte, in emit order
    typedef struct packed {
        logic [1:0]                   last_idx;
        logic [MaxUnits-1:0][15:0]    units;
    } t_bundle;

    localparam logic [1:0] NeedTwo   = 2'd1;
    localparam logic [1:0] NeedThree = 2'd2;
    localparam logic [1:0] NeedFour  = 2'd3;

    localparam logic [7:0]  ContMask   = 8'b1100_0000;
    localparam logic [7:0]  ContTag    = 8'b1000_0000;
    localparam logic [7:0]  Lead2Limit = 8'b1110_0000;
    localparam logic [7:0]  Lead3Limit = 8'b1111_0000;
    localparam logic [7:0]  Lead4Limit = 8'b1111_1000;

    localparam logic [20:0] MinTwo     = 21'h00080;
    localparam logic [20:0] MinThree   = 21'h00800;
    localparam logic [20:0] MinFour    = 21'h10000;
    localparam logic [20:0] MaxCode    = 21'h10FFFF;
    localparam logic [15:0] HighBase   = 16'hD800;
    localparam logic [15:0] LowBase    = 16'hDC00;

endpackage

FILE: hdl/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// UTF-8 byte stream in, UTF-16 code units out.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready, i_data): one UTF-8 byte per transaction,
// with end_of_stream on the final byte of a stream.
// Output channel (o_valid/i_ready, o_data): one UTF-16 code unit per
// transaction; last_unit marks the final unit caused by an input byte.
// A byte causes zero to four units: a lead or middle continuation byte
// causes none unless it ends the stream, a completed four-byte sequence
// causes a surrogate pair, and invalid sequences are flushed as Latin-1
// units. The first unit of a byte is offered from the queue head. The
// decoder takes one byte per cycle while the queue is not full; the output
// side drains one unit per cycle while the receiver is ready, so sustained
// rate is set by the output port when bytes expand to more than one unit.
// A queue of QUEUE_DEPTH decoded bundles sits between decoder and output;
// when the receiver stalls, the queue fills and o_ready drops.
// Reset clears the pending sequence and empties the queue.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  u2u_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output u2u_pkg::t_out_item o_data
);
    import u2u_pkg::*;

    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    t_bundle bundle;
    t_bundle head;

    u2u_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_full   (full),
        .o_push   (push),
        .o_bundle (bundle)
    );

    u2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .i_pop    (pop),
        .o_head   (head),
        .o_full   (full),
        .o_empty  (empty)
    );

    u2u_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

FILE: hdl/u2u_front.sv
// ----------------------------------------------------------------------------
// u2u_front
// Accepts UTF-8 bytes, tracks the pending sequence and decodes each byte
// into a bundle of zero to four UTF-16 code units for the queue.
// ----------------------------------------------------------------------------
module u2u_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  u2u_pkg::t_in_item i_data,
    input  logic              i_full,
    output logic              o_push,
    output u2u_pkg::t_bundle  o_bundle
);
    import u2u_pkg::*;

    logic [7:0]       r_lead, n_lead;
    logic [1:0][7:0]  r_tail, n_tail;
    logic [1:0]       r_need, n_need;
    logic [1:0]       r_have, n_have;

    logic [MaxUnits-1:0][15:0] units;
    logic [2:0]                cnt;
    logic                      accept;

    assign o_ready = ~i_full;
    assign accept  = i_valid & ~i_full;

    always_comb begin
        logic [7:0]  b;
        logic [20:0] c;
        logic [20:0] minv;
        logic [20:0] off;
        logic        do_fresh;
        logic        do_flush;

        b        = i_data.data_byte;
        n_lead   = r_lead;
        n_tail   = r_tail;
        n_need   = r_need;
        n_have   = r_have;
        units    = '0;
        cnt      = '0;
        c        = '0;
        minv     = MinFour;
        off      = '0;
        do_fresh = 1'b0;
        do_flush = 1'b0;

        if (r_need != 2'd0) begin
            if ((b & ContMask) == ContTag) begin
                if ({1'b0, r_have} + 3'd1 < {1'b0, r_need}) begin
                    n_tail[r_have[0]] = b;
                    n_have            = r_have + 2'd1;
                end else begin
                    // last continuation: assemble code point
                    if (r_need == NeedTwo) begin
                        c    = {16'd0, r_lead[4:0]};
                        minv = MinTwo;
                    end else if (r_need == NeedThree) begin
                        c    = {17'd0, r_lead[3:0]};
                        minv = MinThree;
                    end else begin
                        c    = {18'd0, r_lead[2:0]};
                        minv = MinFour;
                    end
                    if (r_have != 2'd0) c = {c[14:0], r_tail[0][5:0]};
                    if (r_have >= 2'd2) c = {c[14:0], r_tail[1][5:0]};
                    c = {c[14:0], b[5:0]};

                    if (c < minv || c > MaxCode) begin
                        // overlong or out of range: everything as Latin-1
                        do_flush = 1'b1;
                    end else if (c >= MinFour) begin
                        off = c - MinFour;
                        units[cnt[1:0]] = HighBase + {6'd0, off[19:10]};
                        cnt = cnt + 3'd1;
                        units[cnt[1:0]] = LowBase + {6'd0, c[9:0]};
                        cnt = cnt + 3'd1;
                    end else begin
                        units[cnt[1:0]] = c[15:0];
                        cnt = cnt + 3'd1;
                    end
                    n_lead = '0;
                    n_tail = '0;
                    n_need = '0;
                    n_have = '0;
                end
            end else begin
                do_flush = 1'b1;
                do_fresh = 1'b1;
            end
        end else begin
            do_fresh = 1'b1;
        end

        if (do_flush) begin
            units[cnt[1:0]] = {8'h00, r_lead};
            cnt = cnt + 3'd1;
            if (r_have != 2'd0) begin
                units[cnt[1:0]] = {8'h00, r_tail[0]};
                cnt = cnt + 3'd1;
            end
            if (r_have >= 2'd2) begin
                units[cnt[1:0]] = {8'h00, r_tail[1]};
                cnt = cnt + 3'd1;
            end
            n_lead = '0;
            n_tail = '0;
            n_need = '0;
            n_have = '0;
            // invalid completion also emits the current byte
            if (!do_fresh) begin
                units[cnt[1:0]] = {8'h00, b};
                cnt = cnt + 3'd1;
            end
        end

        if (do_fresh) begin
            if (b < Lead2Limit && b >= 8'hC0) begin
                n_lead = b;
                n_need = NeedTwo;
                n_have = '0;
            end else if (b >= Lead2Limit && b < Lead3Limit) begin
                n_lead = b;
                n_need = NeedThree;
                n_have = '0;
            end else if (b >= Lead3Limit && b < Lead4Limit) begin
                n_lead = b;
                n_need = NeedFour;
                n_have = '0;
            end else begin
                // ASCII, stray continuation or bad lead
                units[cnt[1:0]] = {8'h00, b};
                cnt = cnt + 3'd1;
            end
        end

        // end of stream: flush whatever is still pending
        if (i_data.end_of_stream && n_need != 2'd0) begin
            units[cnt[1:0]] = {8'h00, n_lead};
            cnt = cnt + 3'd1;
            if (n_have != 2'd0) begin
                units[cnt[1:0]] = {8'h00, n_tail[0]};
                cnt = cnt + 3'd1;
            end
            if (n_have >= 2'd2) begin
                units[cnt[1:0]] = {8'h00, n_tail[1]};
                cnt = cnt + 3'd1;
            end
            n_lead = '0;
            n_tail = '0;
            n_need = '0;
            n_have = '0;
        end
    end

    assign o_push            = accept & (cnt != 3'd0);
    assign o_bundle.units    = units;
    assign o_bundle.last_idx = 2'(cnt - 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= '0;
            r_tail <= '0;
            r_need <= '0;
            r_have <= '0;
        end else if (accept) begin
            r_lead <= n_lead;
            r_tail <= n_tail;
            r_need <= n_need;
            r_have <= n_have;
        end
    end

endmodule

FILE: hdl/u2u_queue.sv
// ----------------------------------------------------------------------------
// u2u_queue
// Small FIFO of decoded bundles between the decoder and the serializer.
// ----------------------------------------------------------------------------
module u2u_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  u2u_pkg::t_bundle i_bundle,
    input  logic             i_pop,
    output u2u_pkg::t_bundle o_head,
    output logic             o_full,
    output logic             o_empty
);
    import u2u_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (do_pop)  n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (do_push && !do_pop) n_count = r_count + 1'b1;
        else if (!do_push && do_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

endmodule

FILE: hdl/u2u_back.sv
// ----------------------------------------------------------------------------
// u2u_back
// Serializes the queue head bundle into one code unit per transaction.
// ----------------------------------------------------------------------------
module u2u_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  u2u_pkg::t_bundle   i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output u2u_pkg::t_out_item o_data
);
    import u2u_pkg::*;

    logic [1:0] r_idx;
    logic       is_last;
    logic       take;

    assign o_valid          = ~i_empty;
    assign is_last          = (r_idx == i_head.last_idx);
    assign take             = o_valid & i_ready;
    assign o_pop            = take & is_last;
    assign o_data.code_unit = i_head.units[r_idx];
    assign o_data.last_unit = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (take) begin
            r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule
